// ===== src/gqr_pkg.sv =====
// ----------------------------------------------------------------------------
// gqr_pkg
// Shared types and constants for the quantized gemm tile with requantization.
// ----------------------------------------------------------------------------
package gqr_pkg;

   localparam int TILE_ROWS   = 2;
   localparam int TILE_COLS   = 2;
   localparam int NUM_ACC     = TILE_ROWS * TILE_COLS;
   localparam int ACC_W       = 32;
   localparam int ACC_IDX_W   = (NUM_ACC > 1) ? $clog2(NUM_ACC) : 1;
   localparam int BYTE_W      = 8;
   localparam int Q31_BITS    = 31;
   localparam int PROD_W      = 64;
   localparam logic signed [PROD_W-1:0] Q31_HALF = 64'sh0000_0000_4000_0000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_ZERO_POINT  = 3'd0,
      CSR_Q31_MULTIPLIER     = 3'd1,
      CSR_ROUNDING_MASK      = 3'd2,
      CSR_RIGHT_SHIFT        = 3'd3,
      CSR_ROUNDING_THRESHOLD = 3'd4,
      CSR_CLAMP_LOW          = 3'd5,
      CSR_CLAMP_HIGH         = 3'd6,
      CSR_OUTPUT_OFFSET      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]         weight_zero_point;
      logic [30:0]        q31_multiplier;
      logic [30:0]        rounding_mask;
      logic [4:0]         right_shift;
      logic [29:0]        rounding_threshold;
      logic signed [8:0]  clamp_low;
      logic signed [8:0]  clamp_high;
      logic [7:0]         output_offset;
   } cfg_type;

   typedef struct packed {
      logic               first_step;
      logic               last_step;
      logic signed [31:0] bias_col0;
      logic signed [31:0] bias_col1;
      logic [7:0]         act_row0;
      logic [7:0]         act_row1;
      logic [7:0]         wgt_col0;
      logic [7:0]         wgt_col1;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_r0c0;
      logic [7:0] out_r0c1;
      logic [7:0] out_r1c0;
      logic [7:0] out_r1c1;
   } rsp_item_type;

   typedef logic [NUM_ACC-1:0][ACC_W-1:0] tile_type;
   typedef logic [NUM_ACC-1:0][BYTE_W-1:0] tile_bytes_type;

   typedef struct packed {
      logic     valid;
      tile_type tile;
   } tile_msg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_FINISH,
      ST_DELIVER
   } back_state_type;

endpackage

// ===== src/gqr_if.sv =====
// ----------------------------------------------------------------------------
// gqr_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface gqr_req_if;
   logic                  valid;
   logic                  ready;
   gqr_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface gqr_rsp_if;
   logic                  valid;
   logic                  ready;
   gqr_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/gqr_front.sv =====
// ----------------------------------------------------------------------------
// gqr_front
// Accepts reduction steps, updates the tile accumulators and hands a
// finished tile to the queue on the last step.
// ----------------------------------------------------------------------------
module gqr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gqr_pkg::req_item_type req_item,
   input  gqr_pkg::cfg_type      cfg,
   input  logic                  queue_full,
   output gqr_pkg::tile_msg_type push
);
   import gqr_pkg::*;

   tile_type                 acc_ff;
   tile_type                 acc_in;
   logic                     accept;
   logic [7:0]               act    [TILE_ROWS];
   logic [7:0]               wgt    [TILE_COLS];
   logic signed [ACC_W-1:0]  bias   [TILE_COLS];
   logic signed [9:0]        wdiff  [TILE_COLS];
   logic signed [18:0]       prod;
   logic [ACC_W-1:0]         base;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      act[0]  = req_item.act_row0;
      act[1]  = req_item.act_row1;
      wgt[0]  = req_item.wgt_col0;
      wgt[1]  = req_item.wgt_col1;
      bias[0] = req_item.bias_col0;
      bias[1] = req_item.bias_col1;
      for (int c = 0; c < TILE_COLS; c++) begin
         wdiff[c] = $signed({2'b00, wgt[c]}) - $signed({2'b00, cfg.weight_zero_point});
      end
      acc_in = acc_ff;
      prod   = '0;
      base   = '0;
      for (int r = 0; r < TILE_ROWS; r++) begin
         for (int c = 0; c < TILE_COLS; c++) begin
            base = req_item.first_step ? bias[c] : acc_ff[r*TILE_COLS + c];
            prod = $signed({1'b0, act[r]}) * wdiff[c];
            acc_in[r*TILE_COLS + c] = base + {{(ACC_W-19){prod[18]}}, prod};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
      end
   end

   assign push.valid = accept && req_item.last_step;
   assign push.tile  = acc_in;

endmodule

// ===== src/gqr_queue.sv =====
// ----------------------------------------------------------------------------
// gqr_queue
// Short queue of finished tiles between the front and the requantizer.
// ----------------------------------------------------------------------------
module gqr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  gqr_pkg::tile_msg_type push,
   output logic                  full,
   input  logic                  pop,
   output gqr_pkg::tile_msg_type head
);
   import gqr_pkg::*;

   tile_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.tile  = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.tile;
      end
   end

endmodule

// ===== src/gqr_back.sv =====
// ----------------------------------------------------------------------------
// gqr_back
// Requantizes a queued tile one accumulator at a time through a shared
// Q31 multiply, round and clamp unit, then holds the result item.
// ----------------------------------------------------------------------------
module gqr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  gqr_pkg::cfg_type      cfg,
   input  gqr_pkg::tile_msg_type head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gqr_pkg::rsp_item_type rsp_item
);
   import gqr_pkg::*;

   back_state_type             state_ff, state_in;
   logic [ACC_IDX_W-1:0]       idx_ff, idx_in;
   tile_type                   tile_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [ACC_W-1:0]           q_ff, q_in;
   tile_bytes_type             bytes_ff;
   logic [BYTE_W-1:0]          byte_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_item_type               rsp_item_ff;
   logic                       out_free;
   logic                       load_tile;
   logic                       do_mul;
   logic                       do_round;
   logic                       do_finish;
   logic                       deliver;
   logic signed [PROD_W-1:0]   sum;
   logic [ACC_W-1:0]           masked;
   logic signed [ACC_W:0]      rem;
   logic                       round_up;
   logic signed [ACC_W-1:0]    shifted;
   logic signed [ACC_W:0]      v;
   logic signed [ACC_W:0]      lo;
   logic signed [ACC_W:0]      hi;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (head.valid) state_in = ST_MUL;
         ST_MUL:     state_in = ST_ROUND;
         ST_ROUND:   state_in = ST_FINISH;
         ST_FINISH:  if (idx_ff == ACC_IDX_W'(NUM_ACC-1)) state_in = ST_DELIVER;
                     else state_in = ST_MUL;
         ST_DELIVER: if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      load_tile = 1'b0;
      do_mul    = 1'b0;
      do_round  = 1'b0;
      do_finish = 1'b0;
      deliver   = 1'b0;
      unique case (state_ff)
         ST_IDLE:    load_tile = head.valid;
         ST_MUL:     do_mul    = 1'b1;
         ST_ROUND:   do_round  = 1'b1;
         ST_FINISH:  do_finish = 1'b1;
         ST_DELIVER: deliver   = out_free;
         default:    load_tile = 1'b0;
      endcase
   end

   assign pop = load_tile;

   // datapath
   always_comb begin
      prod_in  = $signed(tile_ff[idx_ff]) * $signed({1'b0, cfg.q31_multiplier});
      sum      = prod_ff + Q31_HALF;
      q_in     = sum[Q31_BITS +: ACC_W];
      masked   = {1'b0, q_ff[30:0] & cfg.rounding_mask};
      rem      = $signed({1'b0, masked}) - $signed({{ACC_W{1'b0}}, q_ff[ACC_W-1]});
      round_up = rem > $signed({3'b000, cfg.rounding_threshold});
      shifted  = $signed(q_ff) >>> cfg.right_shift;
      v        = $signed({shifted[ACC_W-1], shifted}) + $signed({{ACC_W{1'b0}}, round_up});
      lo       = {{(ACC_W-8){cfg.clamp_low[8]}}, cfg.clamp_low};
      hi       = {{(ACC_W-8){cfg.clamp_high[8]}}, cfg.clamp_high};
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      byte_in  = v[BYTE_W-1:0] + cfg.output_offset;
   end

   always_comb begin
      idx_in = idx_ff;
      if (load_tile) begin
         idx_in = '0;
      end else if (do_finish) begin
         idx_in = idx_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_tile) tile_ff <= head.tile;
      if (do_mul)    prod_ff <= prod_in;
      if (do_round)  q_ff    <= q_in;
      if (do_finish) bytes_ff[idx_ff] <= byte_in;
      if (deliver) begin
         rsp_item_ff.out_r0c0 <= bytes_ff[0];
         rsp_item_ff.out_r0c1 <= bytes_ff[1];
         rsp_item_ff.out_r1c0 <= bytes_ff[2];
         rsp_item_ff.out_r1c1 <= bytes_ff[3];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== src/quantized_gemm_tile_requant.sv =====
// ----------------------------------------------------------------------------
// quantized_gemm_tile_requant
// 2x2 tile of an unsigned 8-bit quantized matrix product with Q31
// requantization of the finished tile.
//
// req_chan carries one reduction step per item: two activation bytes, two
// weight bytes, two int32 biases that load on first_step, and last_step,
// which closes the tile. Steps are taken one per cycle while the queue has
// room; the accumulators update in the cycle of acceptance.
// A closed tile enters a two-entry queue. The requantizer drains it one
// accumulator at a time through the multiply, round and shift/clamp steps,
// and takes the next tile only once it has passed the last result item to
// its output register. The requantizer sets the sustained tile rate; steps
// keep flowing as long as the queue has room.
// rsp_chan holds its item in an output register until taken; a stalled
// receiver backs up into the queue, and req_chan.ready drops once it is full.
// csr_* writes one setting per cycle, to be done while the block is idle.
// reset clears accumulators, queue and output valid and presets the settings.
// ----------------------------------------------------------------------------
module quantized_gemm_tile_requant (
   input  logic                            clock,
   input  logic                            reset,
   gqr_req_if.sink                         req_chan,
   gqr_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [gqr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gqr_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import gqr_pkg::*;

   cfg_type      cfg_ff;
   tile_msg_type push;
   tile_msg_type head;
   logic         queue_full;
   logic         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_zero_point  <= '0;
         cfg_ff.q31_multiplier     <= 31'h4000_0000;
         cfg_ff.rounding_mask      <= '0;
         cfg_ff.right_shift        <= '0;
         cfg_ff.rounding_threshold <= '0;
         cfg_ff.clamp_low          <= -9'sd255;
         cfg_ff.clamp_high         <= 9'sd255;
         cfg_ff.output_offset      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_WEIGHT_ZERO_POINT:  cfg_ff.weight_zero_point  <= csr_write_data[7:0];
            CSR_Q31_MULTIPLIER:     cfg_ff.q31_multiplier     <= csr_write_data[30:0];
            CSR_ROUNDING_MASK:      cfg_ff.rounding_mask      <= csr_write_data[30:0];
            CSR_RIGHT_SHIFT:        cfg_ff.right_shift        <= csr_write_data[4:0];
            CSR_ROUNDING_THRESHOLD: cfg_ff.rounding_threshold <= csr_write_data[29:0];
            CSR_CLAMP_LOW:          cfg_ff.clamp_low          <= $signed(csr_write_data[8:0]);
            CSR_CLAMP_HIGH:         cfg_ff.clamp_high         <= $signed(csr_write_data[8:0]);
            CSR_OUTPUT_OFFSET:      cfg_ff.output_offset      <= csr_write_data[7:0];
            default:                cfg_ff <= cfg_ff;
         endcase
      end
   end

   gqr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_chan.payload),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   gqr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   gqr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_chan.payload)
   );

endmodule

// ===== src/gqr_checker.sv =====
// ----------------------------------------------------------------------------
// gqr_checker
// Port-level checks on the tile requantizer, bound to the top level.
// ----------------------------------------------------------------------------
module gqr_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          req_last,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [31:0]   rsp_data
);

   // result item holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // no result item right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // back pressure only follows a closed tile
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_ready && req_last))
      else $error("req ready fell without a tile being closed");

endmodule

bind quantized_gemm_tile_requant gqr_checker u_gqr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.payload.last_step),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.payload)
);
